// ----- design/tpci_pkg.sv -----
// shared types and constants for the triangle pixel color interpolator
// no dependencies
`timescale 1ns / 1ps
package tpci_pkg;
  localparam int COORD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int PROD_W  = 34;
  localparam int EDGE_W  = 35;
  localparam int WT_W    = 35;
  localparam int CPROD_W = 43;
  localparam int NUM_W   = 47;
  localparam int DEN_W   = 36;
  localparam int ADDR_W  = 18;
  localparam int DIV_LAT = 9;
  localparam logic [WT_W-1:0] DEGENERATE_LIMIT = WT_W'(3);

  typedef struct packed {
    logic                vld;
    logic                wr;
    logic [ADDR_W-1:0]   addr;
  } tpci_meta_t;

  typedef logic [23:0] tpci_rgb_t;
endpackage

// ----- design/tpci_edge.sv -----
// edge function stages: products, then edges, inside and degenerate tests
// depends on tpci_pkg
`timescale 1ns / 1ps
module tpci_edge #(
  parameter int SCREEN_WIDTH  = 620,
  parameter int SCREEN_HEIGHT = 340
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic signed [tpci_pkg::COORD_W-1:0]    ax,
  input  logic signed [tpci_pkg::COORD_W-1:0]    ay,
  input  logic signed [tpci_pkg::COORD_W-1:0]    bx,
  input  logic signed [tpci_pkg::COORD_W-1:0]    by,
  input  logic signed [tpci_pkg::COORD_W-1:0]    cx,
  input  logic signed [tpci_pkg::COORD_W-1:0]    cy,
  input  tpci_pkg::tpci_rgb_t                    col_a,
  input  tpci_pkg::tpci_rgb_t                    col_b,
  input  tpci_pkg::tpci_rgb_t                    col_c,
  input  logic [9:0]                             pix_x,
  input  logic [8:0]                             pix_y,
  output tpci_pkg::tpci_meta_t                   meta_o,
  output logic [tpci_pkg::WT_W-1:0]              wa_o,
  output logic [tpci_pkg::WT_W-1:0]              wb_o,
  output logic [tpci_pkg::WT_W-1:0]              wc_o,
  output logic [tpci_pkg::WT_W-1:0]              den_o,
  output tpci_pkg::tpci_rgb_t                    col_a_o,
  output tpci_pkg::tpci_rgb_t                    col_b_o,
  output tpci_pkg::tpci_rgb_t                    col_c_o
);
  localparam int DW = tpci_pkg::DIFF_W;
  localparam int PW = tpci_pkg::PROD_W;
  localparam int EW = tpci_pkg::EDGE_W;

  logic signed [DW-1:0] px, py;
  logic signed [PW-1:0] p_nxt [8];
  logic signed [PW-1:0] p_r [8];
  logic                 vld1_r, on1_r;
  logic [31:0]          addr_full;
  logic [tpci_pkg::ADDR_W-1:0] addr1_r;
  tpci_pkg::tpci_rgb_t  ca1_r, cb1_r, cc1_r;

  function automatic logic signed [DW-1:0] sx(input logic signed [tpci_pkg::COORD_W-1:0] v);
    return DW'(v);
  endfunction

  assign px = signed'({3'b000, pix_x, 4'b1000});
  assign py = signed'({4'b0000, pix_y, 4'b1000});

  always_comb begin
    p_nxt[0] = PW'((sx(cx) - sx(ax)) * (sx(by) - sx(ay)));
    p_nxt[1] = PW'((sx(cy) - sx(ay)) * (sx(bx) - sx(ax)));
    p_nxt[2] = PW'((px - sx(bx)) * (sx(cy) - sx(by)));
    p_nxt[3] = PW'((py - sx(by)) * (sx(cx) - sx(bx)));
    p_nxt[4] = PW'((px - sx(cx)) * (sx(ay) - sx(cy)));
    p_nxt[5] = PW'((py - sx(cy)) * (sx(ax) - sx(cx)));
    p_nxt[6] = PW'((px - sx(ax)) * (sx(by) - sx(ay)));
    p_nxt[7] = PW'((py - sx(ay)) * (sx(bx) - sx(ax)));
  end

  assign addr_full = 32'(pix_y) * 32'(SCREEN_WIDTH) + 32'(pix_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) p_r[i] <= p_nxt[i];
      on1_r   <= (32'(pix_x) < 32'(SCREEN_WIDTH)) && (32'(pix_y) < 32'(SCREEN_HEIGHT));
      addr1_r <= addr_full[tpci_pkg::ADDR_W-1:0];
      ca1_r   <= col_a;
      cb1_r   <= col_b;
      cc1_r   <= col_c;
    end
  end

  // stage 2
  logic signed [EW-1:0] area, ea, eb, ec;
  logic [EW-1:0]        den, wa, wb, wc;
  logic                 covered, wr;

  function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
    return v[EW-1] ? EW'(-v) : EW'(v);
  endfunction

  always_comb begin
    area = EW'(p_r[0]) - EW'(p_r[1]);
    ea   = EW'(p_r[2]) - EW'(p_r[3]);
    eb   = EW'(p_r[4]) - EW'(p_r[5]);
    ec   = EW'(p_r[6]) - EW'(p_r[7]);
    den  = mag(area);
    wa   = mag(ea);
    wb   = mag(eb);
    wc   = mag(ec);
    if (area > 0) begin
      covered = !ea[EW-1] && !eb[EW-1] && !ec[EW-1];
    end else begin
      covered = (ea <= 0) && (eb <= 0) && (ec <= 0);
    end
    wr = on1_r && (den >= tpci_pkg::DEGENERATE_LIMIT) && covered;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_o.vld <= 1'b0;
    end else if (en) begin
      meta_o.vld <= vld1_r;
    end
    if (en) begin
      meta_o.wr   <= wr;
      meta_o.addr <= wr ? addr1_r : '0;
      wa_o        <= wa;
      wb_o        <= wb;
      wc_o        <= wc;
      den_o       <= den;
      col_a_o     <= ca1_r;
      col_b_o     <= cb1_r;
      col_c_o     <= cc1_r;
    end
  end
endmodule

// ----- design/tpci_blend.sv -----
// blend stages: channel times weight products, then rounded numerators
// depends on tpci_pkg
`timescale 1ns / 1ps
module tpci_blend (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  tpci_pkg::tpci_meta_t              meta_i,
  input  logic [tpci_pkg::WT_W-1:0]         wa,
  input  logic [tpci_pkg::WT_W-1:0]         wb,
  input  logic [tpci_pkg::WT_W-1:0]         wc,
  input  logic [tpci_pkg::WT_W-1:0]         den,
  input  tpci_pkg::tpci_rgb_t               col_a,
  input  tpci_pkg::tpci_rgb_t               col_b,
  input  tpci_pkg::tpci_rgb_t               col_c,
  output tpci_pkg::tpci_meta_t              meta_o,
  output logic [tpci_pkg::NUM_W-1:0]        num_o [3],
  output logic [tpci_pkg::DEN_W-1:0]        den_o
);
  localparam int CW = tpci_pkg::CPROD_W;
  localparam int NW = tpci_pkg::NUM_W;

  logic [CW-1:0] pa_r [3];
  logic [CW-1:0] pb_r [3];
  logic [CW-1:0] pc_r [3];
  logic [tpci_pkg::WT_W-1:0] den3_r;
  tpci_pkg::tpci_meta_t meta3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta3_r.vld <= 1'b0;
      meta_o.vld  <= 1'b0;
    end else if (en) begin
      meta3_r.vld <= meta_i.vld;
      meta_o.vld  <= meta3_r.vld;
    end
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pa_r[c] <= CW'(col_a[8*c +: 8]) * CW'(wa);
        pb_r[c] <= CW'(col_b[8*c +: 8]) * CW'(wb);
        pc_r[c] <= CW'(col_c[8*c +: 8]) * CW'(wc);
      end
      den3_r       <= den;
      meta3_r.wr   <= meta_i.wr;
      meta3_r.addr <= meta_i.addr;
      for (int c = 0; c < 3; c++) begin
        num_o[c] <= ((NW'(pa_r[c]) + NW'(pb_r[c]) + NW'(pc_r[c])) << 1) + NW'(den3_r);
      end
      den_o       <= {den3_r, 1'b0};
      meta_o.wr   <= meta3_r.wr;
      meta_o.addr <= meta3_r.addr;
    end
  end
endmodule

// ----- design/tpci_div.sv -----
// pipelined restoring divider, one quotient bit per stage, saturating at 255
// depends on tpci_pkg
`timescale 1ns / 1ps
module tpci_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tpci_pkg::NUM_W-1:0]    num,
  input  logic [tpci_pkg::DEN_W-1:0]    den,
  output logic [7:0]                    quo
);
  localparam int NW = tpci_pkg::NUM_W;
  localparam int DW = tpci_pkg::DEN_W;

  logic [NW-1:0] rem_r [9];
  logic [DW-1:0] den_r [9];
  logic [7:0]    q_r   [9];
  logic          sat_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      sat_r[0] <= num >= (NW'(den) << 8);
    end
  end

  for (genvar s = 1; s < 9; s++) begin : g_stage
    logic [NW-1:0] shd;
    logic          take;
    assign shd  = NW'(den_r[s-1]) << (8 - s);
    assign take = rem_r[s-1] >= shd;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= take ? rem_r[s-1] - shd : rem_r[s-1];
        den_r[s] <= den_r[s-1];
        q_r[s]   <= {q_r[s-1][6:0], take};
        sat_r[s] <= sat_r[s-1];
      end
    end
  end

  assign quo = sat_r[8] ? 8'hff : q_r[8];
endmodule

// ----- design/triangle_pixel_color_interpolator.sv -----
// top level of the triangle pixel color interpolator
// depends on tpci_pkg, tpci_edge, tpci_blend, tpci_div
//
//  channel | handshake          | word
//  in      | in_valid/in_stall  | three vertices, three colors, pixel
//  out     | out_valid/out_stall| write flag, address, rgb565
//
// one word per cycle unless a stalled output word freezes the pipeline; stages run edge, blend, divider, output
// the divider pipeline (one quotient bit per stage) sets the latency
// synchronous active-low reset clears valid bits only
// a stalled output word freezes the whole pipeline; in_stall follows it
`timescale 1ns / 1ps
module triangle_pixel_color_interpolator #(
  parameter int SCREEN_WIDTH  = 620,
  parameter int SCREEN_HEIGHT = 340
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_vertex_a_x,
  input  logic signed [15:0] in_vertex_a_y,
  input  logic signed [15:0] in_vertex_b_x,
  input  logic signed [15:0] in_vertex_b_y,
  input  logic signed [15:0] in_vertex_c_x,
  input  logic signed [15:0] in_vertex_c_y,
  input  logic [23:0]        in_color_a,
  input  logic [23:0]        in_color_b,
  input  logic [23:0]        in_color_c,
  input  logic [9:0]         in_pixel_x,
  input  logic [8:0]         in_pixel_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_write_pixel,
  output logic [17:0]        out_pixel_address,
  output logic [15:0]        out_pixel_color
);
  logic en;
  tpci_pkg::tpci_meta_t meta_e, meta_b;
  logic [tpci_pkg::WT_W-1:0] wa, wb, wc, den_e;
  tpci_pkg::tpci_rgb_t ca, cb, cc;
  logic [tpci_pkg::NUM_W-1:0] num [3];
  logic [tpci_pkg::DEN_W-1:0] den_b;
  logic [7:0] quo [3];
  tpci_pkg::tpci_meta_t line_r [tpci_pkg::DIV_LAT];
  logic out_valid_r, out_wr_r;
  logic [17:0] out_addr_r;
  logic [15:0] out_col_r;

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;

  tpci_edge #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_edge (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
    .ax(in_vertex_a_x), .ay(in_vertex_a_y),
    .bx(in_vertex_b_x), .by(in_vertex_b_y),
    .cx(in_vertex_c_x), .cy(in_vertex_c_y),
    .col_a(in_color_a), .col_b(in_color_b), .col_c(in_color_c),
    .pix_x(in_pixel_x), .pix_y(in_pixel_y),
    .meta_o(meta_e), .wa_o(wa), .wb_o(wb), .wc_o(wc), .den_o(den_e),
    .col_a_o(ca), .col_b_o(cb), .col_c_o(cc)
  );

  tpci_blend u_blend (
    .clk(clk), .rst_n(rst_n), .en(en), .meta_i(meta_e),
    .wa(wa), .wb(wb), .wc(wc), .den(den_e),
    .col_a(ca), .col_b(cb), .col_c(cc),
    .meta_o(meta_b), .num_o(num), .den_o(den_b)
  );

  for (genvar c = 0; c < 3; c++) begin : g_div
    tpci_div u_div (
      .clk(clk), .en(en), .num(num[c]), .den(den_b), .quo(quo[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tpci_pkg::DIV_LAT; i++) line_r[i].vld <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      line_r[0].vld <= meta_b.vld;
      for (int i = 1; i < tpci_pkg::DIV_LAT; i++) line_r[i].vld <= line_r[i-1].vld;
      out_valid_r <= line_r[tpci_pkg::DIV_LAT-1].vld;
    end
    if (en) begin
      line_r[0].wr   <= meta_b.wr;
      line_r[0].addr <= meta_b.addr;
      for (int i = 1; i < tpci_pkg::DIV_LAT; i++) begin
        line_r[i].wr   <= line_r[i-1].wr;
        line_r[i].addr <= line_r[i-1].addr;
      end
      out_wr_r   <= line_r[tpci_pkg::DIV_LAT-1].wr;
      out_addr_r <= line_r[tpci_pkg::DIV_LAT-1].addr;
      // blue in byte 0, red in byte 2
      out_col_r  <= line_r[tpci_pkg::DIV_LAT-1].wr ?
                    {quo[2][7:3], quo[1][7:2], quo[0][7:3]} : 16'h0000;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_pixel   = out_wr_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_color   = out_col_r;
endmodule
